@@ design/sacl_pkg.sv @@
// shared constants, types and helpers for the set-associative cache lru tag model
// no dependencies; imported by every module of the block
package sacl_pkg;

   localparam int MAX_SETS    = 256;
   localparam int MAX_WAYS    = 8;
   localparam int SET_W       = $clog2(MAX_SETS);
   localparam int WAY_W       = $clog2(MAX_WAYS);
   localparam int RANK_MAX    = MAX_WAYS - 1;
   localparam int CNT_W       = 32;
   localparam int ADDR_W      = 64;
   localparam int OP_W        = 2;
   localparam int OUTC_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int SETB_W      = 4;
   localparam int BLKB_W      = 6;
   localparam int WAYS_W      = 4;
   localparam int SHIFT_W     = 7;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

   localparam logic [OUTC_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTC_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTC_W-1:0] OUTCOME_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_full;
   } dp_status_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0]            valid;
      logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
   } meta_row_type;

   typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_type;

   // add 0..3 and stick at all ones
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                input logic [1:0] inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt} + (CNT_W+1)'(inc);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

@@ design/sacl_ctrl.sv @@
// controller of the cache tag model: two-state sequencer for accept and commit
// depends on sacl_pkg
module sacl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    rsp_stall,
   input  sacl_pkg::dp_status_type status,
   output logic                    req_stall,
   output sacl_pkg::ctrl_cmd_type  cmd
);
   import sacl_pkg::*;

   typedef enum logic {ST_IDLE, ST_UPDATE} state_type;

   state_type state_ff;
   logic      stall_ff;

   assign req_stall  = stall_ff;
   assign cmd.accept = req_valid && !stall_ff;
   assign cmd.commit = (state_ff == ST_UPDATE) && (!status.out_full || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept) begin
                  state_ff <= ST_UPDATE;
                  stall_ff <= 1'b1;
               end
            end
            ST_UPDATE: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ design/sacl_dpath.sv @@
// datapath of the cache tag model: config, set rows in memory, lookup, lru update, totals
// depends on sacl_pkg; driven by sacl_ctrl commands
module sacl_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  sacl_pkg::ctrl_cmd_type              cmd,
   output sacl_pkg::dp_status_type             status,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [sacl_pkg::OP_W-1:0]           req_op,
   input  logic [sacl_pkg::ADDR_W-1:0]         req_address,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [sacl_pkg::OUTC_W-1:0]         rsp_outcome,
   output logic                                rsp_second_hit,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_hit_total,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_miss_total,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_eviction_total
);
   import sacl_pkg::*;

   // config
   logic [SETB_W-1:0] set_bits_ff;
   logic [BLKB_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0] ways_ff;

   logic [SETB_W-1:0] eff_s;
   logic [WAY_W:0]    nw;

   // address split
   logic [SHIFT_W-1:0] split;
   logic [ADDR_W-1:0]  tag_c;
   logic [ADDR_W-1:0]  set_shift;
   logic [SET_W:0]     set_one;
   logic [SET_W-1:0]   set_mask;
   logic [SET_W-1:0]   set_c;

   // item held over the update cycle
   logic [ADDR_W-1:0] tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic [OP_W-1:0]   op_ff;

   // set memories and per-set valid
   tag_row_type   tag_mem [MAX_SETS];
   meta_row_type  meta_mem [MAX_SETS];
   logic [MAX_SETS-1:0] row_valid_ff;
   tag_row_type   tag_rd_ff;
   meta_row_type  meta_rd_ff;
   logic          rv_rd_ff;

   // lookup
   logic [MAX_WAYS-1:0]            valid_w;
   logic [MAX_WAYS-1:0][WAY_W-1:0] rank_w;
   logic [MAX_WAYS-1:0]            in_use;
   logic [MAX_WAYS-1:0]            match;
   logic [MAX_WAYS-1:0]            empty;
   logic                           hit;
   logic                           has_empty;
   logic [WAY_W-1:0]               hit_way;
   logic [WAY_W-1:0]               empty_way;
   logic [WAY_W-1:0]               victim;
   logic [WAY_W-1:0]               way_sel;
   logic [WAY_W:0]                 old_rank;
   logic [OUTC_W-1:0]              outcome_in;
   meta_row_type                   meta_in;
   tag_row_type                    tags_in;
   logic [1:0]                     hit_inc;
   logic                           second_in;

   // totals and result
   logic [CNT_W-1:0]  hit_cnt_ff;
   logic [CNT_W-1:0]  miss_cnt_ff;
   logic [CNT_W-1:0]  evict_cnt_ff;
   logic [CNT_W-1:0]  hit_cnt_in;
   logic [CNT_W-1:0]  miss_cnt_in;
   logic [CNT_W-1:0]  evict_cnt_in;
   logic              out_valid_ff;
   logic [OUTC_W-1:0] outcome_ff;
   logic              second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[SETB_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[BLKB_W-1:0];
            CSR_WAYS:       ways_ff       <= csr_wdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_s = (set_bits_ff > SETB_W'(SET_W)) ? SETB_W'(SET_W) : set_bits_ff;
      if (ways_ff == '0) begin
         nw = (WAY_W+1)'(1);
      end else if (ways_ff > WAYS_W'(MAX_WAYS)) begin
         nw = (WAY_W+1)'(MAX_WAYS);
      end else begin
         nw = ways_ff[WAY_W:0];
      end
      split     = SHIFT_W'(eff_s) + SHIFT_W'(block_bits_ff);
      tag_c     = (split >= SHIFT_W'(ADDR_W)) ? '0 : (req_address >> split);
      set_shift = req_address >> block_bits_ff;
      set_one   = (SET_W+1)'(1) << eff_s;
      set_mask  = SET_W'(set_one - (SET_W+1)'(1));
      set_c     = set_shift[SET_W-1:0] & set_mask;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tag_ff     <= tag_c;
         set_ff     <= set_c;
         op_ff      <= req_op;
         tag_rd_ff  <= tag_mem[set_c];
         meta_rd_ff <= meta_mem[set_c];
         rv_rd_ff   <= row_valid_ff[set_c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_ff]  <= tags_in;
         meta_mem[set_ff] <= meta_in;
      end
   end

   always_comb begin
      valid_w   = rv_rd_ff ? meta_rd_ff.valid : '0;
      rank_w    = rv_rd_ff ? meta_rd_ff.rank  : '0;
      hit_way   = '0;
      empty_way = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (WAY_W+1)'(i) < nw;
         match[i]  = in_use[i] && valid_w[i] && (tag_rd_ff[i] == tag_ff);
         empty[i]  = in_use[i] && !valid_w[i];
      end
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) hit_way = WAY_W'(i);
         if (empty[i]) empty_way = WAY_W'(i);
      end
      hit       = |match;
      has_empty = |empty;
      // oldest way, lowest on ties
      victim = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (rank_w[i] > rank_w[victim])) victim = WAY_W'(i);
      end
      if (hit) begin
         way_sel    = hit_way;
         old_rank   = {1'b0, rank_w[hit_way]};
         outcome_in = OUTCOME_HIT;
      end else if (has_empty) begin
         way_sel    = empty_way;
         old_rank   = (WAY_W+1)'(MAX_WAYS);
         outcome_in = OUTCOME_FILL;
      end else begin
         way_sel    = victim;
         old_rank   = {1'b0, rank_w[victim]};
         outcome_in = OUTCOME_EVICT;
      end
      // mark selected way most recent, age the younger ones
      meta_in.valid          = valid_w;
      meta_in.valid[way_sel] = 1'b1;
      for (int i = 0; i < MAX_WAYS; i++) begin
         meta_in.rank[i] = rank_w[i];
         if (WAY_W'(i) == way_sel) begin
            meta_in.rank[i] = '0;
         end else if (in_use[i] && valid_w[i] && ({1'b0, rank_w[i]} < old_rank) &&
                      (rank_w[i] < WAY_W'(RANK_MAX))) begin
            meta_in.rank[i] = rank_w[i] + WAY_W'(1);
         end
      end
      tags_in = tag_rd_ff;
      if (!hit) tags_in[way_sel] = tag_ff;
      second_in    = (op_ff == OP_MODIFY);
      hit_inc      = 2'(hit) + 2'(second_in);
      hit_cnt_in   = sat_add(hit_cnt_ff, hit_inc);
      miss_cnt_in  = sat_add(miss_cnt_ff, 2'(!hit));
      evict_cnt_in = sat_add(evict_cnt_ff, 2'(outcome_in == OUTCOME_EVICT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         row_valid_ff[set_ff] <= 1'b1;
         hit_cnt_ff           <= hit_cnt_in;
         miss_cnt_ff          <= miss_cnt_in;
         evict_cnt_ff         <= evict_cnt_in;
         out_valid_ff         <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         outcome_ff <= outcome_in;
         second_ff  <= second_in;
      end
   end

   assign status.out_full    = out_valid_ff;
   assign rsp_valid          = out_valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_second_hit     = second_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule

@@ design/set_assoc_cache_lru_sim.sv @@
// top level of the set-associative cache lru tag model: controller plus datapath
// depends on sacl_pkg, sacl_ctrl, sacl_dpath
//
//   channel   handshake         payload
//   req_      valid / stall     op, address
//   rsp_      valid / stall     outcome, second_hit, hit/miss/eviction totals
//   csr_      valid / ready     index, wdata (set_bits, block_bits, ways)
//
// a beat reads the set row from the tag and lru memories when it is accepted, then
// compares all ways, writes the row back and loads the result register on commit.
// reset loads config defaults, clears totals and per-set valid bits; no clearing pass.
// a result waiting under rsp_stall does not block the next request, but that
// request's update waits until the result register is free.
module set_assoc_cache_lru_sim (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sacl_pkg::OP_W-1:0]           req_op,
   input  logic [sacl_pkg::ADDR_W-1:0]         req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sacl_pkg::OUTC_W-1:0]         rsp_outcome,
   output logic                                rsp_second_hit,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_hit_total,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_miss_total,
   output logic [sacl_pkg::CNT_W-1:0]          rsp_eviction_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sacl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sacl_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_address        (req_address),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_outcome        (rsp_outcome),
      .rsp_second_hit     (rsp_second_hit),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

@@ design/sacl_chk.sv @@
// port-level checks for the set-associative cache lru tag model, bound to the top level
// depends on sacl_pkg and set_assoc_cache_lru_sim
module sacl_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sacl_pkg::OUTC_W-1:0]  rsp_outcome,
   input logic                         rsp_second_hit,
   input logic [sacl_pkg::CNT_W-1:0]   rsp_hit_total,
   input logic [sacl_pkg::CNT_W-1:0]   rsp_miss_total,
   input logic [sacl_pkg::CNT_W-1:0]   rsp_eviction_total
);
   import sacl_pkg::*;

   // one beat at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous beat still in work");

   a_miss_covers_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_miss_total >= rsp_eviction_total))
      else $error("eviction total above miss total");

   a_second_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_second_hit) |-> (rsp_hit_total != '0))
      else $error("second lookup hit not in hit total");

   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUTCOME_EVICT)) |->
         (rsp_eviction_total != '0) && (rsp_miss_total != '0))
      else $error("eviction beat with empty totals");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit_total)))
      else $error("stalled response changed");

endmodule

bind set_assoc_cache_lru_sim sacl_chk u_sacl_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_outcome        (rsp_outcome),
   .rsp_second_hit     (rsp_second_hit),
   .rsp_hit_total      (rsp_hit_total),
   .rsp_miss_total     (rsp_miss_total),
   .rsp_eviction_total (rsp_eviction_total)
);
